@@ design/hrci_pkg.sv @@
// Shared types, constants and helper functions for the hex record character image block.
package hrci_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_EOF       = 3'd1,
        STS_NO_COLON  = 3'd2,
        STS_TOO_SHORT = 3'd3,
        STS_TRUNCATED = 3'd4,
        STS_BAD_DIGIT = 3'd5,
        STS_OUT_RANGE = 3'd6
    } t_status;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_COPY
    } t_back_state;

    // Command word passed from the front end to the back end
    typedef struct packed {
        logic        is_read;
        t_status     status;
        logic [16:0] base;    // image index of the first data character
        logic [8:0]  count2;  // number of data characters
        logic [16:0] ridx;    // image index for a read
    } t_cmd;

    localparam int          IDX_W      = 18;        // image index incl. overflow bit
    localparam logic [9:0]  POS_MAX    = 10'd1023;
    localparam logic [9:0]  LINE_MIN   = 10'd11;
    localparam logic [9:0]  DATA_START = 10'd9;
    localparam logic [9:0]  LEN_FIRST  = 10'd1;
    localparam logic [9:0]  LEN_LAST   = 10'd2;
    localparam logic [9:0]  ADDR_FIRST = 10'd3;
    localparam logic [9:0]  ADDR_LAST  = 10'd6;
    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [7:0]  CH_FILL    = 8'h46;     // 'F'

    // Characters of the end-of-file record ":00000001FF"
    function automatic logic [7:0] eof_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_COLON;
            4'd8:    c = 8'h31;
            4'd9:    c = 8'h46;
            4'd10:   c = 8'h46;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

    // Hex digit decode: {bad, nibble}; a bad digit gives a zero nibble
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else begin
            r = 5'b1_0000;
        end
        return r;
    endfunction

endpackage

@@ design/hex_record_to_char_image_core.sv @@
// Top level of the hex record parser that fills a character image.
//
// Takes one record character (or one image read request) per word and answers with one
// result word at the end of each line and for each read. After reset the image is swept
// to 'F' one entry a cycle, and no input word is taken until that pass ends. The front
// end is through with a record character when it takes it, unless it stalls. A record
// that passes its checks is copied by the back end at one data character per cycle
// through the line buffer's registered read port; until that copy ends, characters of
// the next record stall while read requests still queue. A read request is answered
// through the image memory's registered read port. A two-word queue sits between the
// front end and the back end, and a result register holds each result until it is
// taken; the back end starts no new command while a held result is stalled.
module hex_record_to_char_image_core #(
    parameter int IMAGE_CHARS     = 131072,
    parameter int LINE_DATA_CHARS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    input  logic [16:0] i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_read_char,
    output logic        o_is_read
);
    import hrci_pkg::*;

    localparam int AW  = $clog2(IMAGE_CHARS);
    localparam int LAW = $clog2(LINE_DATA_CHARS);

    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    t_cmd           front_cmd;
    t_cmd           head_cmd;
    logic           clearing;
    logic           copy_done;
    logic [LAW-1:0] line_raddr;
    logic [7:0]     line_rdata;

    // Character intake and classification
    hrci_front #(
        .IMAGE_CHARS     (IMAGE_CHARS),
        .LINE_DATA_CHARS (LINE_DATA_CHARS),
        .LAW             (LAW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .i_read_index  (i_read_index),
        .i_clearing    (clearing),
        .i_fifo_full   (fifo_full),
        .i_copy_done   (copy_done),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_line_raddr  (line_raddr),
        .o_line_rdata  (line_rdata)
    );

    // Command queue
    hrci_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // Image owner: reads, copies, results
    hrci_back #(
        .IMAGE_CHARS     (IMAGE_CHARS),
        .LINE_DATA_CHARS (LINE_DATA_CHARS),
        .AW              (AW),
        .LAW             (LAW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (fifo_empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_copy_done  (copy_done),
        .o_line_raddr (line_raddr),
        .i_line_rdata (line_rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_char  (o_read_char),
        .o_is_read    (o_is_read)
    );

endmodule

@@ design/hrci_front.sv @@
// Front end: takes record characters and read requests, keeps line state and the line buffer.
module hrci_front #(
    parameter int IMAGE_CHARS     = 131072,
    parameter int LINE_DATA_CHARS = 512,
    parameter int LAW             = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [7:0]        i_ch,
    input  logic              i_end_of_line,
    input  logic [16:0]       i_read_index,
    input  logic              i_clearing,
    input  logic              i_fifo_full,
    input  logic              i_copy_done,
    output logic              o_push,
    output hrci_pkg::t_cmd    o_cmd,
    input  logic [LAW-1:0]    i_line_raddr,
    output logic [7:0]        o_line_rdata
);
    import hrci_pkg::*;

    logic [7:0]  r_line_mem [LINE_DATA_CHARS];
    logic [7:0]  r_line_q;

    logic [9:0]  r_pos;
    logic [7:0]  r_len;
    logic [15:0] r_addr;
    logic        r_colon;
    logic        r_bad;
    logic        r_eof;
    logic        r_copy_pend;

    logic [9:0]  n_pos;
    logic [7:0]  n_len;
    logic [15:0] n_addr;
    logic        n_colon;
    logic        n_bad;
    logic        n_eof;

    logic        acc;
    logic        acc_char;
    logic [4:0]  nib;
    logic        in_len;
    logic        in_addr;
    logic [9:0]  lpos;
    logic        line_we;
    logic [8:0]  count2;
    logic [9:0]  need;
    t_status     line_sts;
    t_status     rd_sts;

    // Reads may pass while a copy is pending; characters may not touch the line buffer
    assign o_stall  = i_clearing || i_fifo_full || (!i_func && r_copy_pend);
    assign acc      = i_valid && !o_stall;
    assign acc_char = acc && !i_func;

    // Per-character field update
    always_comb begin
        nib     = hex_nibble(i_ch);
        in_len  = (r_pos >= LEN_FIRST) && (r_pos <= LEN_LAST);
        in_addr = (r_pos >= ADDR_FIRST) && (r_pos <= ADDR_LAST);
        if (r_pos < LINE_MIN) begin
            n_eof = r_eof && (i_ch == eof_char(r_pos[3:0]));
        end else begin
            n_eof = 1'b0;
        end
        n_colon = (r_pos == 10'd0) ? (i_ch == CH_COLON) : r_colon;
        n_len   = in_len  ? {r_len[3:0], nib[3:0]}   : r_len;
        n_addr  = in_addr ? {r_addr[11:0], nib[3:0]} : r_addr;
        n_bad   = r_bad || ((in_len || in_addr) && nib[4]);
        n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + 10'd1;
        lpos    = r_pos - DATA_START;
        line_we = acc_char && (r_pos >= DATA_START) && (32'(lpos) < LINE_DATA_CHARS);
    end

    // End-of-line classification, checks in priority order
    always_comb begin
        count2 = {n_len, 1'b0};
        need   = LINE_MIN + {1'b0, count2};
        if (n_eof && n_pos == LINE_MIN) begin
            line_sts = STS_EOF;
        end else if (!n_colon) begin
            line_sts = STS_NO_COLON;
        end else if (n_pos < LINE_MIN) begin
            line_sts = STS_TOO_SHORT;
        end else if (n_bad) begin
            line_sts = STS_BAD_DIGIT;
        end else if (n_pos < need) begin
            line_sts = STS_TRUNCATED;
        end else begin
            line_sts = STS_OK;
        end
        rd_sts = (32'(i_read_index) < IMAGE_CHARS) ? STS_OK : STS_OUT_RANGE;
    end

    // Command word to the queue
    always_comb begin
        o_push         = acc && (i_func || i_end_of_line);
        o_cmd.is_read  = i_func;
        o_cmd.status   = i_func ? rd_sts : line_sts;
        o_cmd.base     = {n_addr, 1'b0};
        o_cmd.count2   = count2;
        o_cmd.ridx     = i_read_index;
    end

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_addr      <= '0;
            r_colon     <= 1'b0;
            r_bad       <= 1'b0;
            r_eof       <= 1'b1;
            r_copy_pend <= 1'b0;
        end else begin
            if (acc_char) begin
                if (i_end_of_line) begin
                    r_pos   <= '0;
                    r_len   <= '0;
                    r_addr  <= '0;
                    r_colon <= 1'b0;
                    r_bad   <= 1'b0;
                    r_eof   <= 1'b1;
                end else begin
                    r_pos   <= n_pos;
                    r_len   <= n_len;
                    r_addr  <= n_addr;
                    r_colon <= n_colon;
                    r_bad   <= n_bad;
                    r_eof   <= n_eof;
                end
            end
            if (acc_char && i_end_of_line && line_sts == STS_OK) begin
                r_copy_pend <= 1'b1;
            end else if (i_copy_done) begin
                r_copy_pend <= 1'b0;
            end
        end
    end

    // Line buffer: written by characters, read by the back end copy
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[lpos[LAW-1:0]] <= i_ch;
        end
        r_line_q <= r_line_mem[i_line_raddr];
    end

    assign o_line_rdata = r_line_q;

`ifndef NO_ASSERTIONS
    // The line buffer is never overwritten while a copy still needs it
    a_no_char_during_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copy_pend |-> !line_we)
        else $error("line buffer written while copy pending");
`endif

endmodule

@@ design/hrci_fifo.sv @@
// Two-entry command queue between the front end and the back end.
module hrci_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrci_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output hrci_pkg::t_cmd o_cmd
);
    import hrci_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    // No word is pushed into a full queue unless one is popped at the same edge, and none is popped from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");
`endif

endmodule

@@ design/hrci_back.sv @@
// Back end: owns the character image, serves reads and copies record data into it.
module hrci_back #(
    parameter int IMAGE_CHARS     = 131072,
    parameter int LINE_DATA_CHARS = 512,
    parameter int AW              = 17,
    parameter int LAW             = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  hrci_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_copy_done,
    output logic [LAW-1:0] o_line_raddr,
    input  logic [7:0]     i_line_rdata,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [2:0]     o_status,
    output logic [7:0]     o_read_char,
    output logic           o_is_read
);
    import hrci_pkg::*;

    localparam logic [AW-1:0] CLR_LAST = AW'(IMAGE_CHARS - 1);

    logic [7:0]       r_img_mem [IMAGE_CHARS];
    logic [7:0]       r_img_q;

    t_back_state      r_state;
    t_back_state      n_state;
    t_cmd             r_cmd;
    logic [8:0]       r_p;
    logic             r_drop;
    logic             r_wv;
    logic [AW-1:0]    r_widx;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_cnt;
    logic             r_ov;
    t_status          r_ostatus;
    logic [7:0]       r_ochar;
    logic             r_oisread;

    logic             out_free;
    logic             load_out;
    t_status          ld_status;
    logic [7:0]       ld_char;
    logic             ld_is_read;
    logic             issue;
    logic             start_copy;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] cp_idx;
    logic             cp_drop;

    assign out_free   = !r_ov || !i_stall;
    assign o_clearing = r_clr_busy;
    assign rd_idx     = {1'b0, i_cmd.ridx};
    assign cp_idx     = {1'b0, r_cmd.base} + IDX_W'(r_p);
    assign cp_drop    = (32'(r_p) >= LINE_DATA_CHARS) || (32'(cp_idx) >= IMAGE_CHARS);
    assign o_line_raddr = r_p[LAW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!r_clr_busy && !i_empty && out_free && i_cmd.status == STS_OK) begin
                    n_state = i_cmd.is_read ? BK_READ : BK_COPY;
                end
            end
            BK_READ: n_state = BK_IDLE;
            BK_COPY: begin
                if (r_p == r_cmd.count2) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop       = 1'b0;
        o_copy_done = 1'b0;
        load_out    = 1'b0;
        ld_status   = STS_OK;
        ld_char     = 8'd0;
        ld_is_read  = 1'b0;
        issue       = 1'b0;
        start_copy  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!r_clr_busy && !i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.status == STS_OK) begin
                        start_copy = !i_cmd.is_read;
                    end else begin
                        // Result known without touching the image
                        load_out   = 1'b1;
                        ld_status  = i_cmd.status;
                        ld_is_read = i_cmd.is_read;
                    end
                end
            end
            BK_READ: begin
                load_out   = 1'b1;
                ld_char    = r_img_q;
                ld_is_read = 1'b1;
            end
            BK_COPY: begin
                if (r_p == r_cmd.count2) begin
                    load_out    = 1'b1;
                    ld_status   = r_drop ? STS_OUT_RANGE : STS_OK;
                    o_copy_done = 1'b1;
                end else begin
                    issue = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_wv       <= 1'b0;
            r_ov       <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_p        <= '0;
            r_drop     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= issue && !cp_drop;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (start_copy) begin
                r_p    <= '0;
                r_drop <= 1'b0;
            end else if (issue) begin
                r_p    <= r_p + 9'd1;
                r_drop <= r_drop || cp_drop;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_widx <= cp_idx[AW-1:0];
        end
        if (load_out) begin
            r_ostatus <= ld_status;
            r_ochar   <= ld_char;
            r_oisread <= ld_is_read;
        end
    end

    // Image memory: clearing pass or copy writes, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_img_mem[r_clr_cnt] <= CH_FILL;
        end else if (r_wv) begin
            r_img_mem[r_widx] <= i_line_rdata;
        end
        r_img_q <= r_img_mem[rd_idx[AW-1:0]];
    end

    assign o_valid     = r_ov;
    assign o_status    = r_ostatus;
    assign o_read_char = r_ochar;
    assign o_is_read   = r_oisread;

`ifndef NO_ASSERTIONS
    // A held result is never overwritten
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_ov || !i_stall))
        else $error("output word overwritten");
    // No copy write can land during the clearing pass
    a_no_copy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_wv && r_state == BK_IDLE))
        else $error("image access during clearing pass");
    // A copy ends only for a line command and returns a line result
    a_copy_done_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_copy_done |=> (r_ov && !r_oisread))
        else $error("copy finished without a line result");
`endif

endmodule

@@ verif/hrci_image_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the hex record parser: mirrors line and image state, predicts, compares.
module hrci_image_checker #(
    parameter int IMAGE_CHARS     = 131072,
    parameter int LINE_DATA_CHARS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    input  logic [16:0] i_read_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_read_char,
    input  logic        i_is_read,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_lines_seen,
    output int          o_reads_seen
);
    import hrci_pkg::*;

    // End-of-file record text, first character in the top byte
    localparam logic [87:0] EOF_RECORD   = ":00000001FF";
    localparam logic [9:0]  LINE_POS_MAX = 10'd1023;
    localparam int          MIN_CHARS    = 11;
    localparam int          DATA_POS     = 9;

    typedef struct {
        t_status    status;
        logic [7:0] read_char;
        logic       is_read;
    } t_result;

    t_result     due_results[$];
    logic [7:0]  image_mem [IMAGE_CHARS];
    logic [7:0]  line_mem [LINE_DATA_CHARS];
    logic [9:0]  char_pos;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic        colon_ok;
    logic        digit_err;
    logic        eof_like;

    // Line state back to its idle values; the line buffer keeps its contents
    task automatic clear_line();
        char_pos  = 10'd0;
        rec_len   = 8'd0;
        rec_addr  = 16'd0;
        colon_ok  = 1'b0;
        digit_err = 1'b0;
        eof_like  = 1'b1;
    endtask

    // Value of a hex digit; a non-digit yields zero and returns 0
    function automatic logic digit_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            v = c[3:0] + 4'd9;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // End-of-line checks, then the copy of the data characters into the image
    function automatic t_status finish_record();
        int      count2;
        int      base;
        t_status s;
        s      = STS_OK;
        count2 = 2 * int'(rec_len);
        base   = 2 * int'(rec_addr);
        if (eof_like && int'(char_pos) == MIN_CHARS) return STS_EOF;
        if (!colon_ok) return STS_NO_COLON;
        if (int'(char_pos) < MIN_CHARS) return STS_TOO_SHORT;
        if (digit_err) return STS_BAD_DIGIT;
        if (int'(char_pos) < MIN_CHARS + count2) return STS_TRUNCATED;
        for (int p = 0; p < count2; p++) begin
            if (p >= LINE_DATA_CHARS || base + p >= IMAGE_CHARS) begin
                s = STS_OUT_RANGE;
            end else begin
                image_mem[base + p] = line_mem[p];
            end
        end
        return s;
    endfunction

    // One record character into the line state
    task automatic take_char(input logic [7:0] c, input logic eol);
        logic [3:0] v;
        logic       ok;
        t_result    r;
        if (int'(char_pos) >= MIN_CHARS || c != EOF_RECORD[87 - 8 * char_pos -: 8]) begin
            eof_like = 1'b0;
        end
        if (char_pos == 10'd0) begin
            colon_ok = (c == ":");
        end else if (char_pos <= 10'd2) begin
            ok        = digit_value(c, v);
            digit_err = digit_err | !ok;
            rec_len   = {rec_len[3:0], v};
        end else if (char_pos <= 10'd6) begin
            ok        = digit_value(c, v);
            digit_err = digit_err | !ok;
            rec_addr  = {rec_addr[11:0], v};
        end else if (int'(char_pos) >= DATA_POS && int'(char_pos) - DATA_POS < LINE_DATA_CHARS) begin
            line_mem[int'(char_pos) - DATA_POS] = c;
        end
        if (char_pos != LINE_POS_MAX) char_pos = char_pos + 10'd1;
        if (eol) begin
            r.status    = finish_record();
            r.read_char = 8'd0;
            r.is_read   = 1'b0;
            due_results.push_back(r);
            clear_line();
        end
    endtask

    task automatic log_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    // Outputs are checked before the new input word is predicted: a result never
    // answers the word accepted on the same edge
    always @(posedge i_clk) begin : monitor
        t_result r;
        if (!i_rst_n) begin
            foreach (image_mem[k]) image_mem[k] = CH_FILL;
            clear_line();
            due_results.delete();
            o_fail_count = 0;
            o_lines_seen = 0;
            o_reads_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    log_failure($sformatf("unexpected result: status %0d char %02h read %0b",
                                          i_status, i_read_char, i_is_read));
                end else begin
                    r = due_results.pop_front();
                    if (r.is_read) o_reads_seen++;
                    else o_lines_seen++;
                    if (r.status !== i_status || r.read_char !== i_read_char ||
                        r.is_read !== i_is_read) begin
                        log_failure($sformatf({"mismatch: expected status %0d char %02h read %0b,",
                                               " got status %0d char %02h read %0b"},
                                              r.status, r.read_char, r.is_read,
                                              i_status, i_read_char, i_is_read));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func) begin
                    if (int'(i_read_index) < IMAGE_CHARS) begin
                        r.status    = STS_OK;
                        r.read_char = image_mem[i_read_index];
                    end else begin
                        r.status    = STS_OUT_RANGE;
                        r.read_char = 8'd0;
                    end
                    r.is_read = 1'b1;
                    due_results.push_back(r);
                end else begin
                    take_char(i_ch, i_end_of_line);
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

@@ verif/hex_record_to_char_image_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the hex record parser: record, noise and read stimulus plus the verdict.
module hex_record_to_char_image_core_tb;
    import hrci_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [7:0]  i_ch;
    logic        i_end_of_line;
    logic [16:0] i_read_index;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_read_char;
    logic        o_is_read;

    int          fail_count;
    int          pending;
    int          lines_seen;
    int          reads_seen;

    bit   [7:0]  line_q[$];
    int          words_sent = 0;
    bit          calm = 1'b0;
    logic [16:0] last_base = 17'd0;
    int          last_len = 0;

    always #5 i_clk = ~i_clk;

    hex_record_to_char_image_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_char   (o_read_char),
        .o_is_read     (o_is_read)
    );

    hrci_image_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_func        (i_func),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .i_read_index  (i_read_index),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_status      (o_status),
        .i_read_char   (o_read_char),
        .i_is_read     (o_is_read),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_lines_seen  (lines_seen),
        .o_reads_seen  (reads_seen)
    );

    // Result side backpressure
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 22);
    end

    // One word on the input channel; called and left at a falling edge
    task automatic put_word(input logic f, input logic [7:0] c, input logic e,
                            input logic [16:0] r);
        while (!calm && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_ch          <= c;
        i_end_of_line <= e;
        i_read_index  <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        calm = (words_sent >= 400 && words_sent < 700);
    endtask

    task automatic put_read(input logic [16:0] idx);
        put_word(1'b1, 8'($urandom), 1'($urandom), idx);
    endtask

    // Mostly reads around the last record written, some anywhere
    function automatic logic [16:0] pick_read_index();
        case ($urandom_range(0, 5))
            0:       return 17'($urandom);
            1:       return $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
            default: return last_base + 17'($urandom_range(0, 2 * last_len + 3));
        endcase
    endfunction

    // Hex digits of a value, mixed case
    task automatic push_hex(input int value, input int digits);
        logic [3:0] nib;
        for (int d = digits - 1; d >= 0; d--) begin
            nib = 4'(value >> (4 * d));
            if (nib < 4'd10) begin
                line_q.push_back("0" + nib);
            end else if ($urandom_range(0, 1)) begin
                line_q.push_back("A" + nib - 8'd10);
            end else begin
                line_q.push_back("a" + nib - 8'd10);
            end
        end
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) line_q.push_back(s[k]);
    endtask

    // Data record with a well-formed header and random type, data and checksum; some data characters are not hex digits
    task automatic build_record(input int len, input logic [15:0] addr);
        line_q.push_back(":");
        push_hex(len, 2);
        push_hex(addr, 4);
        push_hex($urandom_range(0, 5), 2);
        for (int k = 0; k < 2 * len; k++) begin
            if ($urandom_range(0, 99) < 85) push_hex($urandom_range(0, 15), 1);
            else line_q.push_back(8'($urandom));
        end
        push_hex($urandom_range(0, 255), 2);
        last_base = {addr, 1'b0};
        last_len  = len;
    endtask

    // Send the built line, end of line on its last character, reads mixed in
    task automatic send_line();
        for (int k = 0; k < line_q.size(); k++) begin
            if ($urandom_range(0, 99) < 4) put_read(pick_read_index());
            put_word(1'b0, line_q[k], k == line_q.size() - 1, 17'($urandom));
        end
        line_q.delete();
    endtask

    initial begin : stimulus
        int          flavor;
        int          len;
        logic [15:0] addr;
        logic [7:0]  c;
        bit          long_done;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = 1'b0;
        i_ch          = 8'd0;
        i_end_of_line = 1'b0;
        i_read_index  = 17'd0;
        i_stall       = 1'b0;
        long_done     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: end-of-file record, no colon with extreme characters, too short,
        // bad length digit, reads at both ends of the image
        push_text(":00000001FF");
        send_line();
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        send_line();
        push_text(":0");
        send_line();
        push_text(":0G00000000");
        send_line();
        put_read(17'h00000);
        put_read(17'h1FFFF);

        // Random part: mostly good records, then broken ones, noise and read bursts
        while (words_sent < 1500) begin
            flavor = $urandom_range(0, 99);
            len    = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 64);
            if ($urandom_range(0, 99) == 0) len = $urandom_range(128, 255);
            addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
            if ($urandom_range(0, 9) == 0) addr = 16'hFFFF - 16'($urandom_range(0, len));
            if (!long_done && words_sent >= 800) begin
                // one line long enough to saturate the position counter
                long_done = 1'b1;
                build_record(255, addr);
                while (line_q.size() < 1030) push_hex($urandom_range(0, 15), 1);
                send_line();
            end else if (flavor < 60) begin
                build_record(len, addr);
                send_line();
            end else if (flavor < 70) begin
                // truncated record
                build_record(len, addr);
                repeat ($urandom_range(1, 2 * len + 2)) void'(line_q.pop_back());
                send_line();
            end else if (flavor < 75) begin
                // non-digit in the length or address field
                build_record(len, addr);
                case ($urandom_range(0, 4))
                    0:       c = "G";
                    1:       c = "g";
                    2:       c = 8'h20;
                    3:       c = 8'hC1;
                    default: c = "/";
                endcase
                line_q[$urandom_range(1, 6)] = c;
                send_line();
            end else if (flavor < 79) begin
                build_record(len, addr);
                line_q[0] = 8'($urandom);
                send_line();
            end else if (flavor < 83) begin
                line_q.push_back(":");
                repeat ($urandom_range(0, 9)) push_hex($urandom_range(0, 15), 1);
                send_line();
            end else if (flavor < 87) begin
                // end-of-file record, exact or near miss
                push_text(":00000001FF");
                case ($urandom_range(0, 2))
                    1: begin
                        line_q[9]  = "f";
                        line_q[10] = "f";
                    end
                    2:       push_hex($urandom_range(0, 15), 1);
                    default: ;
                endcase
                send_line();
            end else if (flavor < 90) begin
                repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom));
                send_line();
            end else begin
                repeat ($urandom_range(1, 4)) put_read(pick_read_index());
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        $display("Sent %0d words: %0d line results and %0d image reads checked, %0d failures.",
                 words_sent, lines_seen, reads_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS hex_record_to_char_image_core");
        end else begin
            $display("FAIL hex_record_to_char_image_core");
        end
        $finish;
    end

    // Run limit: clearing pass plus the whole stimulus, several times over
    initial begin
        #5_000_000;
        $display("FAIL hex_record_to_char_image_core");
        $finish;
    end

endmodule
